// File: sv/ias_pkg.sv
package ias_pkg;

  // Sizes of the element store and the range stack.
  localparam int unsigned DEPTH       = 64;
  localparam int unsigned STACK_DEPTH = 8;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ADDR_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned STK_AW      = $clog2(STACK_DEPTH);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [SP_W-1:0]          sp_t;

  // Controller states.
  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SORT_INIT,
    ST_PART_START,
    ST_PART_PIV,
    ST_PART_RDJ,
    ST_PART_CMP,
    ST_PART_SW1,
    ST_PART_SW2,
    ST_FIN_WR1,
    ST_FIN_WR2,
    ST_DECIDE,
    ST_SMALL,
    ST_POP,
    ST_INS_START,
    ST_INS_RDI,
    ST_INS_KEY,
    ST_INS_CHK,
    ST_INS_CMP,
    ST_INS_NEXT,
    ST_EMIT_START,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_DONE
  } state_e;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_IDLE,
    OP_LOAD,
    OP_INIT_RANGE,
    OP_RD_HI,
    OP_LD_PIVOT,
    OP_RD_J,
    OP_RD_PLACE,
    OP_ADV_J,
    OP_ADV_BOTH,
    OP_SWAP_RD,
    OP_SWAP_WR_PLACE,
    OP_SWAP_WR_J,
    OP_FIN_WR_PLACE,
    OP_FIN_WR_HI,
    OP_DECIDE,
    OP_SMALL,
    OP_POP,
    OP_INS_INIT,
    OP_INS_RD_I,
    OP_INS_LD_KEY,
    OP_INS_RD_JM1,
    OP_INS_SHIFT,
    OP_INS_WR_KEY,
    OP_INS_INC_I,
    OP_EMIT_INIT,
    OP_EMIT_RD,
    OP_EMIT_LOAD,
    OP_CLEAR
  } op_e;

  // Command from controller to datapath.
  typedef struct packed {
    op_e op;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic last_taken;
    logic few;
    logic j_at_hi;
    logic less;
    logic place_eq_j;
    logic big_ok;
    logic stack_full;
    logic small_ok;
    logic stack_empty;
    logic j_at_ins_lo;
    logic greater;
    logic i_at_hi;
    logic out_free;
    logic k_last;
  } status_t;

endpackage

// File: sv/integer_array_sorter.sv
// Batch sorter for signed 32-bit words.
// Input channel (in_valid_i, in_stall_o, value_i, last_i): one word is taken
// per cycle while the block is loading; in_stall_o stays high while a batch
// is sorted and read out. The word with last_i set closes the batch. Words
// beyond the 64-entry store are dropped and set the overflow flag.
// Output channel (out_valid_o, out_stall_i, sorted_value_o, final_res_o,
// overflow_o): the batch comes out in ascending order, final_res_o marks the
// last word, and overflow_o tells whether words of the batch were dropped.
// The sort is Lomuto quicksort with an explicit range stack, run over the
// store with its one write port and one registered read port; a larger part
// that does not fit on the full stack is sorted by insertion sort instead.
// Readout reads each word from the store and then loads it into the output
// register; a stall holds the output word and pauses the readout. Loading
// resumes after the final word is handed to the output register.
// Reset empties the store, clears the overflow flag and returns the block to
// loading; the output channel comes up idle.
module integer_array_sorter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [31:0]  value_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [31:0]  sorted_value_o,
  output logic                final_res_o,
  output logic                overflow_o
);

  ias_pkg::cmd_t    cmd;
  ias_pkg::status_t status;

  // Input is taken only while the controller is loading.
  assign in_stall_o = cmd.op != ias_pkg::OP_LOAD;

  // Sequencer.
  ias_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Store, stack and output register.
  ias_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_valid_i     (in_valid_i),
    .value_i        (value_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sorted_value_o (sorted_value_o),
    .final_res_o    (final_res_o),
    .overflow_o     (overflow_o)
  );

endmodule

// File: sv/ias_ctrl.sv
module ias_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ias_pkg::status_t status_i,
  output ias_pkg::cmd_t    cmd_o
);

  ias_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ias_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = ias_pkg::OP_IDLE;
    unique case (state_q)
      ias_pkg::ST_LOAD: begin
        cmd_o.op = ias_pkg::OP_LOAD;
        if (status_i.last_taken) state_d = ias_pkg::ST_SORT_INIT;
      end
      ias_pkg::ST_SORT_INIT: begin
        if (status_i.few) begin
          state_d = ias_pkg::ST_EMIT_START;
        end else begin
          cmd_o.op = ias_pkg::OP_INIT_RANGE;
          state_d  = ias_pkg::ST_PART_START;
        end
      end
      // Partition of the range lo..hi around the element at hi.
      ias_pkg::ST_PART_START: begin
        cmd_o.op = ias_pkg::OP_RD_HI;
        state_d  = ias_pkg::ST_PART_PIV;
      end
      ias_pkg::ST_PART_PIV: begin
        cmd_o.op = ias_pkg::OP_LD_PIVOT;
        state_d  = ias_pkg::ST_PART_RDJ;
      end
      ias_pkg::ST_PART_RDJ: begin
        if (status_i.j_at_hi) begin
          cmd_o.op = ias_pkg::OP_RD_PLACE;
          state_d  = ias_pkg::ST_FIN_WR1;
        end else begin
          cmd_o.op = ias_pkg::OP_RD_J;
          state_d  = ias_pkg::ST_PART_CMP;
        end
      end
      ias_pkg::ST_PART_CMP: begin
        if (status_i.less && !status_i.place_eq_j) begin
          cmd_o.op = ias_pkg::OP_SWAP_RD;
          state_d  = ias_pkg::ST_PART_SW1;
        end else if (status_i.less) begin
          cmd_o.op = ias_pkg::OP_ADV_BOTH;
          state_d  = ias_pkg::ST_PART_RDJ;
        end else begin
          cmd_o.op = ias_pkg::OP_ADV_J;
          state_d  = ias_pkg::ST_PART_RDJ;
        end
      end
      ias_pkg::ST_PART_SW1: begin
        cmd_o.op = ias_pkg::OP_SWAP_WR_PLACE;
        state_d  = ias_pkg::ST_PART_SW2;
      end
      ias_pkg::ST_PART_SW2: begin
        cmd_o.op = ias_pkg::OP_SWAP_WR_J;
        state_d  = ias_pkg::ST_PART_RDJ;
      end
      ias_pkg::ST_FIN_WR1: begin
        cmd_o.op = ias_pkg::OP_FIN_WR_PLACE;
        state_d  = ias_pkg::ST_FIN_WR2;
      end
      ias_pkg::ST_FIN_WR2: begin
        cmd_o.op = ias_pkg::OP_FIN_WR_HI;
        state_d  = ias_pkg::ST_DECIDE;
      end
      // Push the larger part, or sort it in place when the stack is full.
      ias_pkg::ST_DECIDE: begin
        cmd_o.op = ias_pkg::OP_DECIDE;
        if (status_i.big_ok && status_i.stack_full) begin
          state_d = ias_pkg::ST_INS_START;
        end else begin
          state_d = ias_pkg::ST_SMALL;
        end
      end
      ias_pkg::ST_SMALL: begin
        if (status_i.small_ok) begin
          cmd_o.op = ias_pkg::OP_SMALL;
          state_d  = ias_pkg::ST_PART_START;
        end else begin
          state_d = ias_pkg::ST_POP;
        end
      end
      ias_pkg::ST_POP: begin
        if (status_i.stack_empty) begin
          state_d = ias_pkg::ST_EMIT_START;
        end else begin
          cmd_o.op = ias_pkg::OP_POP;
          state_d  = ias_pkg::ST_PART_START;
        end
      end
      // Insertion sort of the range that did not fit on the stack.
      ias_pkg::ST_INS_START: begin
        cmd_o.op = ias_pkg::OP_INS_INIT;
        state_d  = ias_pkg::ST_INS_RDI;
      end
      ias_pkg::ST_INS_RDI: begin
        cmd_o.op = ias_pkg::OP_INS_RD_I;
        state_d  = ias_pkg::ST_INS_KEY;
      end
      ias_pkg::ST_INS_KEY: begin
        cmd_o.op = ias_pkg::OP_INS_LD_KEY;
        state_d  = ias_pkg::ST_INS_CHK;
      end
      ias_pkg::ST_INS_CHK: begin
        if (status_i.j_at_ins_lo) begin
          cmd_o.op = ias_pkg::OP_INS_WR_KEY;
          state_d  = ias_pkg::ST_INS_NEXT;
        end else begin
          cmd_o.op = ias_pkg::OP_INS_RD_JM1;
          state_d  = ias_pkg::ST_INS_CMP;
        end
      end
      ias_pkg::ST_INS_CMP: begin
        if (status_i.greater) begin
          cmd_o.op = ias_pkg::OP_INS_SHIFT;
          state_d  = ias_pkg::ST_INS_CHK;
        end else begin
          cmd_o.op = ias_pkg::OP_INS_WR_KEY;
          state_d  = ias_pkg::ST_INS_NEXT;
        end
      end
      ias_pkg::ST_INS_NEXT: begin
        if (status_i.i_at_hi) begin
          state_d = ias_pkg::ST_SMALL;
        end else begin
          cmd_o.op = ias_pkg::OP_INS_INC_I;
          state_d  = ias_pkg::ST_INS_RDI;
        end
      end
      // Read out the sorted batch: read a word, then load it once the output is free.
      ias_pkg::ST_EMIT_START: begin
        cmd_o.op = ias_pkg::OP_EMIT_INIT;
        state_d  = ias_pkg::ST_EMIT_RD;
      end
      ias_pkg::ST_EMIT_RD: begin
        cmd_o.op = ias_pkg::OP_EMIT_RD;
        state_d  = ias_pkg::ST_EMIT_LD;
      end
      ias_pkg::ST_EMIT_LD: begin
        if (status_i.out_free) begin
          cmd_o.op = ias_pkg::OP_EMIT_LOAD;
          state_d  = status_i.k_last ? ias_pkg::ST_DONE : ias_pkg::ST_EMIT_RD;
        end
      end
      ias_pkg::ST_DONE: begin
        cmd_o.op = ias_pkg::OP_CLEAR;
        state_d  = ias_pkg::ST_LOAD;
      end
      default: begin
        state_d = ias_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

// File: sv/ias_datapath.sv
module ias_datapath (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ias_pkg::cmd_t    cmd_i,
  output ias_pkg::status_t status_o,
  input  logic             in_valid_i,
  input  ias_pkg::data_t   value_i,
  input  logic             last_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output ias_pkg::data_t   sorted_value_o,
  output logic             final_res_o,
  output logic             overflow_o
);

  // Element store.
  ias_pkg::data_t store_mem [ias_pkg::DEPTH];
  ias_pkg::data_t rdata_q;

  // Control registers.
  ias_pkg::cnt_t  count_q;
  logic           dropped_q;
  ias_pkg::sp_t   sp_q;
  logic           out_valid_q;

  // Working registers.
  ias_pkg::addr_t lo_q, hi_q, j_q, place_q, i_q, ins_lo_q, ins_hi_q, k_q;
  ias_pkg::data_t pivot_q, vj_q, key_q;
  ias_pkg::addr_t stk_lo_q [ias_pkg::STACK_DEPTH];
  ias_pkg::addr_t stk_hi_q [ias_pkg::STACK_DEPTH];
  ias_pkg::data_t out_value_q;
  logic           out_final_q, out_ovf_q;

  logic           load_word;
  logic           room;
  logic           rd_en, wr_en;
  ias_pkg::addr_t rd_addr, wr_addr;
  ias_pkg::data_t wr_data;
  ias_pkg::addr_t left_sz, right_sz, min_sz, max_sz;
  logic           left_le;
  ias_pkg::addr_t big_lo, big_hi, small_lo, small_hi;
  ias_pkg::addr_t p_inc, p_dec, j_dec;
  ias_pkg::sp_t   sp_dec;
  logic [ias_pkg::STK_AW-1:0] push_idx, pop_idx;
  logic           out_free;

  assign load_word = (cmd_i.op == ias_pkg::OP_LOAD) && in_valid_i;
  assign room      = count_q < ias_pkg::cnt_t'(ias_pkg::DEPTH);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Split of the partitioned range into its larger and smaller part.
  assign p_inc    = place_q + ias_pkg::addr_t'(1);
  assign p_dec    = place_q - ias_pkg::addr_t'(1);
  assign j_dec    = j_q - ias_pkg::addr_t'(1);
  assign left_sz  = place_q - lo_q;
  assign right_sz = hi_q - place_q;
  assign left_le  = left_sz <= right_sz;
  assign min_sz   = left_le ? left_sz : right_sz;
  assign max_sz   = left_le ? right_sz : left_sz;
  assign big_lo   = left_le ? p_inc : lo_q;
  assign big_hi   = left_le ? hi_q : p_dec;
  assign small_lo = left_le ? lo_q : p_inc;
  assign small_hi = left_le ? p_dec : hi_q;

  assign sp_dec   = sp_q - ias_pkg::sp_t'(1);
  assign push_idx = sp_q[ias_pkg::STK_AW-1:0];
  assign pop_idx  = sp_dec[ias_pkg::STK_AW-1:0];

  // Status toward the controller.
  always_comb begin
    status_o.last_taken  = load_word && last_i;
    status_o.few         = count_q < ias_pkg::cnt_t'(2);
    status_o.j_at_hi     = j_q == hi_q;
    status_o.less        = rdata_q < pivot_q;
    status_o.place_eq_j  = place_q == j_q;
    status_o.big_ok      = max_sz >= ias_pkg::addr_t'(2);
    status_o.stack_full  = sp_q == ias_pkg::sp_t'(ias_pkg::STACK_DEPTH);
    status_o.small_ok    = min_sz >= ias_pkg::addr_t'(2);
    status_o.stack_empty = sp_q == '0;
    status_o.j_at_ins_lo = j_q == ins_lo_q;
    status_o.greater     = rdata_q > key_q;
    status_o.i_at_hi     = i_q == ins_hi_q;
    status_o.out_free    = out_free;
    status_o.k_last      = (ias_pkg::cnt_t'(k_q) + ias_pkg::cnt_t'(1)) == count_q;
  end

  // Store port selection per operation.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = j_q;
    wr_en   = 1'b0;
    wr_addr = j_q;
    wr_data = rdata_q;
    unique case (cmd_i.op)
      ias_pkg::OP_LOAD: begin
        wr_en   = load_word && room;
        wr_addr = count_q[ias_pkg::ADDR_W-1:0];
        wr_data = value_i;
      end
      ias_pkg::OP_RD_HI: begin
        rd_en   = 1'b1;
        rd_addr = hi_q;
      end
      ias_pkg::OP_RD_J: begin
        rd_en   = 1'b1;
        rd_addr = j_q;
      end
      ias_pkg::OP_RD_PLACE, ias_pkg::OP_SWAP_RD: begin
        rd_en   = 1'b1;
        rd_addr = place_q;
      end
      ias_pkg::OP_SWAP_WR_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = place_q;
        wr_data = vj_q;
      end
      ias_pkg::OP_SWAP_WR_J, ias_pkg::OP_INS_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = j_q;
        wr_data = rdata_q;
      end
      ias_pkg::OP_FIN_WR_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = place_q;
        wr_data = pivot_q;
      end
      ias_pkg::OP_FIN_WR_HI: begin
        wr_en   = 1'b1;
        wr_addr = hi_q;
        wr_data = rdata_q;
      end
      ias_pkg::OP_INS_RD_I: begin
        rd_en   = 1'b1;
        rd_addr = i_q;
      end
      ias_pkg::OP_INS_RD_JM1: begin
        rd_en   = 1'b1;
        rd_addr = j_dec;
      end
      ias_pkg::OP_INS_WR_KEY: begin
        wr_en   = 1'b1;
        wr_addr = j_q;
        wr_data = key_q;
      end
      ias_pkg::OP_EMIT_RD: begin
        rd_en   = 1'b1;
        rd_addr = k_q;
      end
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  // Store with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= store_mem[rd_addr];
  end

  // Fill count, drop flag, stack pointer and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_word) begin
        if (room) begin
          count_q <= count_q + ias_pkg::cnt_t'(1);
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (cmd_i.op == ias_pkg::OP_CLEAR) begin
        count_q   <= '0;
        dropped_q <= 1'b0;
      end
      unique case (cmd_i.op)
        ias_pkg::OP_INIT_RANGE, ias_pkg::OP_CLEAR: begin
          sp_q <= '0;
        end
        ias_pkg::OP_DECIDE: begin
          if (status_o.big_ok && !status_o.stack_full) sp_q <= sp_q + ias_pkg::sp_t'(1);
        end
        ias_pkg::OP_POP: begin
          sp_q <= sp_dec;
        end
        default: begin
          sp_q <= sp_q;
        end
      endcase
      if (cmd_i.op == ias_pkg::OP_EMIT_LOAD) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Range bounds, indexes, pivot, key, stack entries and output word.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      ias_pkg::OP_INIT_RANGE: begin
        lo_q <= '0;
        hi_q <= ias_pkg::addr_t'(count_q - ias_pkg::cnt_t'(1));
      end
      ias_pkg::OP_RD_HI: begin
        j_q     <= lo_q;
        place_q <= lo_q;
      end
      ias_pkg::OP_LD_PIVOT: begin
        pivot_q <= rdata_q;
      end
      ias_pkg::OP_ADV_J: begin
        j_q <= j_q + ias_pkg::addr_t'(1);
      end
      ias_pkg::OP_ADV_BOTH, ias_pkg::OP_SWAP_WR_J: begin
        j_q     <= j_q + ias_pkg::addr_t'(1);
        place_q <= p_inc;
      end
      ias_pkg::OP_SWAP_RD: begin
        vj_q <= rdata_q;
      end
      ias_pkg::OP_DECIDE: begin
        if (status_o.big_ok) begin
          if (!status_o.stack_full) begin
            stk_lo_q[push_idx] <= big_lo;
            stk_hi_q[push_idx] <= big_hi;
          end else begin
            ins_lo_q <= big_lo;
            ins_hi_q <= big_hi;
          end
        end
      end
      ias_pkg::OP_SMALL: begin
        lo_q <= small_lo;
        hi_q <= small_hi;
      end
      ias_pkg::OP_POP: begin
        lo_q <= stk_lo_q[pop_idx];
        hi_q <= stk_hi_q[pop_idx];
      end
      ias_pkg::OP_INS_INIT: begin
        i_q <= ins_lo_q + ias_pkg::addr_t'(1);
      end
      ias_pkg::OP_INS_RD_I: begin
        j_q <= i_q;
      end
      ias_pkg::OP_INS_LD_KEY: begin
        key_q <= rdata_q;
      end
      ias_pkg::OP_INS_SHIFT: begin
        j_q <= j_dec;
      end
      ias_pkg::OP_INS_INC_I: begin
        i_q <= i_q + ias_pkg::addr_t'(1);
      end
      ias_pkg::OP_EMIT_INIT: begin
        k_q <= '0;
      end
      ias_pkg::OP_EMIT_LOAD: begin
        out_value_q <= rdata_q;
        out_final_q <= status_o.k_last;
        out_ovf_q   <= dropped_q;
        k_q         <= k_q + ias_pkg::addr_t'(1);
      end
      default: begin
        k_q <= k_q;
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign final_res_o    = out_final_q;
  assign overflow_o     = out_ovf_q;

endmodule
